/* rtl/core/kncs_pkg.sv */
// Shared types and constants of the k-nearest candidate select block.
package kncs_pkg;

	localparam int MAX_K_DEF        = 16;
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int DIST_BITS_DEF    = 32;

	localparam int VERTEX_W  = 10;
	localparam int DIST_IN_W = 32;
	localparam int RANK_W    = 4;
	localparam int COUNT_W   = 5;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	// register index is the word address, paddr[2]
	localparam logic REG_NEIGHBOURS_WANTED = 1'b0;
	localparam logic [COUNT_W-1:0] NW_RESET = 5'd8;

	typedef struct packed {
		logic [VERTEX_W-1:0]  source_vertex;
		logic [VERTEX_W-1:0]  partner_vertex;
		logic [DIST_IN_W-1:0] distance;
		logic                 reachable;
		logic                 row_end;
	} kncs_in_t;

	typedef struct packed {
		logic [VERTEX_W-1:0] neighbour;
		logic [RANK_W-1:0]   rank;
		logic [COUNT_W-1:0]  found_count;
		logic                entry_valid;
		logic                last_of_row;
	} kncs_out_t;

	typedef struct packed {
		logic load;     // input word taken this cycle
		logic advance;  // result word taken this cycle
	} kncs_cmd_t;

	typedef struct packed {
		logic last_word;  // result on display is the final one of the row
	} kncs_status_t;

endpackage

/* rtl/core/kncs_stream_if.sv */
// Valid/ready stream channel carrying one word of a chosen payload type.
interface kncs_stream_if #(parameter type word_t = logic);
	logic  valid;
	logic  ready;
	word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/kncs_cfg_regs.sv */
// APB register file holding neighbours_wanted and deriving the effective k.
module kncs_cfg_regs #(
	parameter int MAX_K        = kncs_pkg::MAX_K_DEF,
	parameter int MAX_VERTICES = kncs_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kncs_pkg::ADDR_W-1:0]   paddr,
	input  logic [kncs_pkg::DATA_W-1:0]   pwdata,
	output logic [kncs_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [$clog2(MAX_K+1)-1:0]    k
);
	import kncs_pkg::*;

	localparam int KW   = $clog2(MAX_K + 1);
	localparam int KLIM = (MAX_K < MAX_VERTICES - 1) ? MAX_K : MAX_VERTICES - 1;

	logic [COUNT_W-1:0] nw_q;
	logic               sel_nw;
	logic               wr_en;

	assign pready = 1'b1;
	assign sel_nw = (paddr[2] == REG_NEIGHBOURS_WANTED);
	assign wr_en  = psel && penable && pwrite && pready && sel_nw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nw_q <= NW_RESET;
		end else if (wr_en) begin
			nw_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_nw) begin
			prdata = DATA_W'(nw_q);
		end
	end

	// saturate to the list depth and to the number of other vertices
	always_comb begin
		if (32'(nw_q) > 32'(KLIM)) begin
			k = KW'(KLIM);
		end else begin
			k = KW'(nw_q);
		end
	end

endmodule

/* rtl/core/kncs_ctrl.sv */
// Controller: alternates between taking candidate words and draining a row's results.
module kncs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_row_end,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output kncs_pkg::kncs_cmd_t    cmd,
	input  kncs_pkg::kncs_status_t status
);
	import kncs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		out_valid   = (state_q == ST_EMIT);
		cmd.load    = in_valid && in_ready;
		cmd.advance = out_valid && out_ready;
		state_d     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load && in_row_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.advance && status.last_word) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/kncs_datapath.sv */
// Datapath: sorted shift-insert list of kept partners, kept count and emit counter.
module kncs_datapath #(
	parameter int MAX_K        = kncs_pkg::MAX_K_DEF,
	parameter int MAX_VERTICES = kncs_pkg::MAX_VERTICES_DEF,
	parameter int DIST_BITS    = kncs_pkg::DIST_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kncs_pkg::kncs_cmd_t           cmd,
	output kncs_pkg::kncs_status_t        status,
	input  kncs_pkg::kncs_in_t            cand,
	input  logic [$clog2(MAX_K+1)-1:0]    k,
	output kncs_pkg::kncs_out_t           result
);
	import kncs_pkg::*;

	localparam int KW = $clog2(MAX_K + 1);
	localparam int IW = $clog2(MAX_K);
	localparam int DW = (DIST_BITS < DIST_IN_W) ? DIST_BITS : DIST_IN_W;

	logic [VERTEX_W-1:0] part_q [MAX_K];
	logic [DW-1:0]       dist_q [MAX_K];
	logic [KW-1:0]       kept_q, kept_d;
	logic [IW-1:0]       rank_q;
	logic [KW-1:0]       k_m1, last_idx, n_word;
	logic [MAX_K-1:0]    stop;
	logic [DW-1:0]       cand_d;
	logic                cand_ok;
	logic                ins;

	always_comb begin
		cand_d  = cand.distance[DW-1:0];
		cand_ok = cand.reachable
			&& (cand.partner_vertex != cand.source_vertex)
			&& (32'(cand.partner_vertex) < 32'(MAX_VERTICES))
			&& (k != '0);
		k_m1 = k - KW'(1);
		// The kept entries stay sorted, so stop is a thermometer code:
		// it rises at the insert position and stays high above it.
		for (int i = 0; i < MAX_K; i++) begin
			stop[i] = (KW'(i) >= kept_q)
				|| (cand_d < dist_q[i])
				|| ((cand_d == dist_q[i]) && (cand.partner_vertex < part_q[i]));
		end
		ins      = cmd.load && cand_ok && stop[k_m1[IW-1:0]];
		last_idx = (kept_q < k) ? kept_q : k_m1;
		n_word   = (kept_q < k) ? kept_q : k;
		kept_d   = kept_q;
		if (ins && (kept_q < k)) begin
			kept_d = kept_q + KW'(1);
		end
	end

	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (ins && stop[0]) begin
					part_q[0] <= cand.partner_vertex;
					dist_q[0] <= cand_d;
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (ins) begin
					if (stop[i] && !stop[i-1]) begin
						part_q[i] <= cand.partner_vertex;
						dist_q[i] <= cand_d;
					end else if (stop[i-1] && (KW'(i) <= last_idx)) begin
						part_q[i] <= part_q[i-1];
						dist_q[i] <= dist_q[i-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
			rank_q <= '0;
		end else if (cmd.advance && status.last_word) begin
			kept_q <= '0;
			rank_q <= '0;
		end else if (cmd.advance) begin
			rank_q <= rank_q + IW'(1);
		end else begin
			kept_q <= kept_d;
		end
	end

	always_comb begin
		status.last_word   = (n_word == '0) || ((KW'(rank_q) + KW'(1)) == n_word);
		result.neighbour   = (n_word == '0) ? '0 : part_q[rank_q];
		result.rank        = RANK_W'(rank_q);
		result.found_count = COUNT_W'(n_word);
		result.entry_valid = (n_word != '0);
		result.last_of_row = status.last_word;
	end

endmodule

/* rtl/core/k_nearest_candidate_select.sv */
// Top level of the k-nearest candidate select block.
//
// Usage: stream one row of a distance matrix into cand, one edge per word
// (source, partner, distance, reachable, row_end). The block keeps the k
// nearest reachable partners other than the source itself, ordered by rising
// distance and then by lower partner index; k is neighbours_wanted (APB,
// byte address 0, reset 8) saturated to MAX_K and MAX_VERTICES - 1.
// Edge words that do not end a row are taken one per cycle: the compare of the
// candidate against every list cell and the shift-insert finish in the cycle
// the word is taken. The word carrying row_end is considered first; the first
// result appears on result in the cycle after it is taken, then one result per
// cycle, nearest first, while the receiver takes them. Each has rank,
// found_count and last_of_row. A row that kept nothing gives one word with
// entry_valid low. While a row drains, cand is held off.
// If the receiver stalls, the current result holds and the drain pauses.
// Reset clears the kept count and drain counter, sets neighbours_wanted to 8;
// the list cells need no clearing, only entries below the kept count are read.
// Write the register only between rows or while no result is pending.
module k_nearest_candidate_select #(
	parameter int MAX_K        = kncs_pkg::MAX_K_DEF,
	parameter int MAX_VERTICES = kncs_pkg::MAX_VERTICES_DEF,
	parameter int DIST_BITS    = kncs_pkg::DIST_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	kncs_stream_if.sink                  cand,
	kncs_stream_if.source                result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [kncs_pkg::ADDR_W-1:0]  paddr,
	input  logic [kncs_pkg::DATA_W-1:0]  pwdata,
	output logic [kncs_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import kncs_pkg::*;

	logic [$clog2(MAX_K+1)-1:0] k;
	kncs_cmd_t                  cmd;
	kncs_status_t               status;
	kncs_in_t                   cand_word;
	kncs_out_t                  result_word;
	logic                       in_ready;
	logic                       out_valid;

	assign cand_word      = cand.payload;
	assign cand.ready     = in_ready;
	assign result.valid   = out_valid;
	assign result.payload = result_word;

	// register file: neighbours_wanted and the saturated k
	kncs_cfg_regs #(
		.MAX_K        (MAX_K),
		.MAX_VERTICES (MAX_VERTICES)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.k       (k)
	);

	// controller: take edges, then drain the row on row_end
	kncs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cand.valid),
		.in_row_end (cand_word.row_end),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (result.ready),
		.cmd        (cmd),
		.status     (status)
	);

	// datapath: sorted list, kept count, emit counter
	kncs_datapath #(
		.MAX_K        (MAX_K),
		.MAX_VERTICES (MAX_VERTICES),
		.DIST_BITS    (DIST_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.cand   (cand_word),
		.k      (k),
		.result (result_word)
	);

endmodule
